// ===== rtl/core/mal_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mal_pkg
// Shared types and constants of the moving-average level block.
// ----------------------------------------------------------------------------
package mal_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int PCT_W      = 7;
	localparam int NUM_W      = 23;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [PCT_W-1:0]    PCT_MAX        = 7'd100;
	localparam logic [NUM_W-1:0]    PCT_SCALE      = 23'd100;
	localparam logic [SAMPLE_W-1:0] SPAN_LOW_RST   = 16'd0;
	localparam logic [SAMPLE_W-1:0] SPAN_HIGH_RST  = 16'd32640;

	localparam logic REG_SPAN_LOW  = 1'b0;
	localparam logic REG_SPAN_HIGH = 1'b1;

	typedef enum logic {
		DIV_AVG,
		DIV_PCT
	} div_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV1,
		ST_WAIT1,
		ST_MAP,
		ST_DIV2,
		ST_WAIT2,
		ST_FINISH
	} mal_state_t;

	typedef struct packed {
		logic     load_in;
		logic     update;
		logic     div_start;
		div_sel_t div_sel;
		logic     avg_load;
		logic     map;
		logic     pct_load;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic span_zero;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/mal_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mal_in_if / mal_out_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface mal_in_if;
	logic                          valid;
	logic                          ready;
	logic [mal_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface mal_out_if;
	logic                          valid;
	logic                          ready;
	logic [mal_pkg::PCT_W-1:0]     level_percent;
	logic [mal_pkg::SAMPLE_W-1:0]  average;
	logic                          span_fault;

	modport source (output valid, output level_percent, output average,
		output span_fault, input ready);
	modport sink   (input valid, input level_percent, input average,
		input span_fault, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mal_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mal_regs
// APB register file holding the span end points.
// ----------------------------------------------------------------------------
module mal_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [mal_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [mal_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [mal_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready,
	output logic      [mal_pkg::SAMPLE_W-1:0]     span_low,
	output logic      [mal_pkg::SAMPLE_W-1:0]     span_high
);
	import mal_pkg::*;

	logic                wr_en;
	logic                reg_idx;
	logic [SAMPLE_W-1:0] span_low_q;
	logic [SAMPLE_W-1:0] span_high_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_low_q  <= SPAN_LOW_RST;
			span_high_q <= SPAN_HIGH_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SPAN_LOW:  span_low_q  <= pwdata[SAMPLE_W-1:0];
				REG_SPAN_HIGH: span_high_q <= pwdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SPAN_LOW:  prdata = APB_DATA_W'(span_low_q);
			REG_SPAN_HIGH: prdata = APB_DATA_W'(span_high_q);
			default:       prdata = '0;
		endcase
	end

	assign span_low  = span_low_q;
	assign span_high = span_high_q;

endmodule
`default_nettype wire

// ===== rtl/core/mal_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mal_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mal_div #(
	parameter int DIV_W = 23,
	parameter int DVS_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic      [DIV_W-1:0] quotient
);
	localparam int CW = (DIV_W > 1) ? $clog2(DIV_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVS_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_shift;
	logic [DVS_W:0]   rem_diff;
	logic             q_bit;

	assign rem_shift = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
	assign rem_diff  = rem_shift - {1'b0, dvs_q};
	assign q_bit     = ~rem_diff[DVS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= q_bit ? rem_diff : rem_shift;
			quo_q <= {quo_q[DIV_W-2:0], q_bit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held");

endmodule
`default_nettype wire

// ===== rtl/core/mal_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mal_dp
// Datapath: sample ring, running sum, shared divider, percent mapping and
// result register.
// ----------------------------------------------------------------------------
module mal_dp #(
	parameter int WINDOW = 10
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mal_pkg::ctrl_cmd_t            cmd,
	output mal_pkg::dp_stat_t                  stat,
	input  wire logic [mal_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic [mal_pkg::SAMPLE_W-1:0]  span_low,
	input  wire logic [mal_pkg::SAMPLE_W-1:0]  span_high,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic      [mal_pkg::PCT_W-1:0]     level_percent,
	output logic      [mal_pkg::SAMPLE_W-1:0]  average,
	output logic                               span_fault
);
	import mal_pkg::*;

	localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
	localparam int DIV_W = (SUM_W > NUM_W) ? SUM_W : NUM_W;

	logic [SAMPLE_W-1:0] win_mem [WINDOW];

	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] old_s1;
	logic [PW-1:0]       pos_q;
	logic                filled_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    count_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [NUM_W-1:0]    num_mag_q;
	logic                num_neg_q;
	logic [SAMPLE_W-1:0] den_mag_q;
	logic                den_neg_q;
	logic                fault_q;
	logic [PCT_W-1:0]    pct_q;

	logic                out_valid_q;
	logic [PCT_W-1:0]    out_pct_q;
	logic [SAMPLE_W-1:0] out_avg_q;
	logic                out_fault_q;

	logic                pos_last;
	logic                filled_nx;
	logic [SAMPLE_W:0]   num_diff;
	logic [SAMPLE_W:0]   den_diff;
	logic [SAMPLE_W-1:0] num_mag;
	logic [SAMPLE_W-1:0] den_mag;
	logic [DIV_W-1:0]    div_dividend;
	logic [SAMPLE_W-1:0] div_divisor;
	logic                div_done;
	logic [DIV_W-1:0]    div_quo;

	assign pos_last  = (pos_q == PW'(WINDOW - 1));
	assign filled_nx = filled_q | pos_last;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_s1 <= sample;
			old_s1    <= win_mem[pos_q];
		end
		if (cmd.update) begin
			win_mem[pos_q] <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= 1'b0;
			sum_q    <= '0;
		end else if (cmd.update) begin
			pos_q    <= pos_last ? '0 : pos_q + 1'b1;
			filled_q <= filled_nx;
			sum_q    <= sum_q - (filled_q ? SUM_W'(old_s1) : '0) + SUM_W'(sample_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			count_q <= filled_nx ? CNT_W'(WINDOW) : CNT_W'(pos_q) + 1'b1;
		end
	end

	assign div_dividend = (cmd.div_sel == DIV_AVG) ? DIV_W'(sum_q) : DIV_W'(num_mag_q);
	assign div_divisor  = (cmd.div_sel == DIV_AVG) ? SAMPLE_W'(count_q) : den_mag_q;

	mal_div #(
		.DIV_W (DIV_W),
		.DVS_W (SAMPLE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign num_diff = {1'b0, avg_q} - {1'b0, span_low};
	assign den_diff = {1'b0, span_high} - {1'b0, span_low};
	assign num_mag  = num_diff[SAMPLE_W] ? SAMPLE_W'(-num_diff) : num_diff[SAMPLE_W-1:0];
	assign den_mag  = den_diff[SAMPLE_W] ? SAMPLE_W'(-den_diff) : den_diff[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.avg_load) begin
			avg_q <= div_quo[SAMPLE_W-1:0];
		end
		if (cmd.map) begin
			num_mag_q <= NUM_W'(num_mag) * PCT_SCALE;
			num_neg_q <= num_diff[SAMPLE_W];
			den_mag_q <= den_mag;
			den_neg_q <= den_diff[SAMPLE_W];
			fault_q   <= (span_high == span_low);
			pct_q     <= '0;
		end else if (cmd.pct_load) begin
			if ((num_neg_q ^ den_neg_q) || (div_quo == '0)) begin
				pct_q <= '0;
			end else if (div_quo > DIV_W'(PCT_MAX)) begin
				pct_q <= PCT_MAX;
			end else begin
				pct_q <= div_quo[PCT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pct_q   <= pct_q;
			out_avg_q   <= avg_q;
			out_fault_q <= fault_q;
		end
	end

	assign stat.div_done  = div_done;
	assign stat.span_zero = (span_high == span_low);
	assign stat.out_free  = ~out_valid_q | out_ready;

	assign out_valid     = out_valid_q;
	assign level_percent = out_pct_q;
	assign average       = out_avg_q;
	assign span_fault    = out_fault_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(WINDOW - 1))
		else $error("ring position out of range");
	a_fill_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(filled_q) |-> pos_q == '0)
		else $error("window filled without wrap");
	a_pct_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_pct_q <= PCT_MAX)
		else $error("percent above limit");
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_fault_q) |-> out_pct_q == '0)
		else $error("percent nonzero on span fault");

endmodule
`default_nettype wire

// ===== rtl/core/mal_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mal_ctrl
// Sequencer: accept, ring update, average divide, percent divide (skipped on a zero span), result.
// ----------------------------------------------------------------------------
module mal_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mal_pkg::dp_stat_t  stat,
	output mal_pkg::ctrl_cmd_t      cmd
);
	import mal_pkg::*;

	mal_state_t state_q;
	mal_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		cmd         = '0;
		cmd.div_sel = DIV_AVG;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nx    = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nx   = ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div_start = 1'b1;
				state_nx      = ST_WAIT1;
			end
			ST_WAIT1: begin
				if (stat.div_done) begin
					cmd.avg_load = 1'b1;
					state_nx     = ST_MAP;
				end
			end
			ST_MAP: begin
				cmd.map  = 1'b1;
				state_nx = stat.span_zero ? ST_FINISH : ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_sel   = DIV_PCT;
				cmd.div_start = 1'b1;
				state_nx      = ST_WAIT2;
			end
			ST_WAIT2: begin
				cmd.div_sel = DIV_PCT;
				if (stat.div_done) begin
					cmd.pct_load = 1'b1;
					state_nx     = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/moving_average_level_percent_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// moving_average_level_percent_top
// Moving-average level filter with percent-of-span output.
// ----------------------------------------------------------------------------
// Each sample transaction produces one result transaction: the truncated mean
// of the last WINDOW samples (fewer during warm-up), that mean mapped onto the
// span_low..span_high range as a percentage clamped to 0..100, and a fault
// flag when the span is zero. One sample is processed at a time. A single
// shared divider (DIV_W = 23 at the default WINDOW) retires one quotient bit
// per cycle and runs twice per sample, once on a zero span. A finished result
// waits in an output register, so the next sample is taken while it is
// still pending. Span registers sit at byte addresses 0 (span_low) and 4
// (span_high), written by the user while idle; the block does not enforce it.
module moving_average_level_percent_top #(
	parameter int WINDOW = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	mal_in_if.sink                                 in_ch,
	mal_out_if.source                              out_ch,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [mal_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [mal_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [mal_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready
);
	import mal_pkg::*;

	ctrl_cmd_t           cmd;
	dp_stat_t            stat;
	logic [SAMPLE_W-1:0] span_low;
	logic [SAMPLE_W-1:0] span_high;

	mal_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.span_low  (span_low),
		.span_high (span_high)
	);

	mal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mal_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.sample        (in_ch.sample),
		.span_low      (span_low),
		.span_high     (span_high),
		.out_ready     (out_ch.ready),
		.out_valid     (out_ch.valid),
		.level_percent (out_ch.level_percent),
		.average       (out_ch.average),
		.span_fault    (out_ch.span_fault)
	);

endmodule
`default_nettype wire

// ===== bench/tb_moving_average_level_percent_top.sv =====
// ----------------------------------------------------------------------------
// tb_moving_average_level_percent_top
// Self-checking bench for the moving-average level filter.
// ----------------------------------------------------------------------------
// Samples go in through a valid/ready driver fed from a queue. Each accepted
// sample updates a local window/sum model and queues the expected percent,
// average and span fault. A monitor checks every result transaction against
// the oldest expectation. Span registers are rewritten over APB between
// phases while the block is idle; phases use reset values, zero span,
// inverted, full, narrow and random spans. Both channels stall in random
// bursts in most phases but never in the final phase.
// ----------------------------------------------------------------------------
module tb_moving_average_level_percent_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mal_pkg::*;

	localparam int WIN        = 10;
	localparam int SETTLE     = 64;
	localparam int STALL_MAX  = 4000;
	localparam int PHASE_ITEMS = 155;

	localparam logic [APB_ADDR_W-1:0] ADDR_SPAN_LOW  = {REG_SPAN_LOW, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_SPAN_HIGH = {REG_SPAN_HIGH, 2'b00};

	typedef struct packed {
		logic [PCT_W-1:0]    pct;
		logic [SAMPLE_W-1:0] avg;
		logic                fault;
	} level_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	mal_in_if  in_ch ();
	mal_out_if out_ch ();

	moving_average_level_percent_top #(.WINDOW(WIN)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	logic [SAMPLE_W-1:0] sample_q[$];
	level_t              level_exp[$];
	int                  err_cnt = 0;

	// filter model state
	logic [SAMPLE_W-1:0] win_buf[WIN];
	int unsigned         win_pos = 0;
	bit                  win_full = 1'b0;
	int unsigned         win_sum = 0;
	logic [SAMPLE_W-1:0] span_lo = SPAN_LOW_RST;
	logic [SAMPLE_W-1:0] span_hi = SPAN_HIGH_RST;

	bit src_bursty;
	bit snk_bursty;
	int src_hold;
	int snk_hold;
	int quiet_cycles;

	function automatic void predict_level(input logic [SAMPLE_W-1:0] s);
		level_t      r;
		int unsigned cnt;
		longint      den;
		longint      num;
		longint      pct;
		if (win_full)
			win_sum -= win_buf[win_pos];
		win_sum += s;
		win_buf[win_pos] = s;
		if (win_pos == WIN - 1)
			win_full = 1'b1;
		cnt = win_full ? WIN : win_pos + 1;
		r.avg = SAMPLE_W'(win_sum / cnt);
		win_pos = (win_pos == WIN - 1) ? 0 : win_pos + 1;
		den = longint'(span_hi) - longint'(span_lo);
		if (den == 0) begin
			r.fault = 1'b1;
			pct = 0;
		end else begin
			r.fault = 1'b0;
			num = 100 * (longint'(r.avg) - longint'(span_lo));
			pct = num / den;
			if (pct > 100)
				pct = 100;
			if (pct < 0)
				pct = 0;
		end
		r.pct = PCT_W'(pct);
		level_exp.push_back(r);
	endfunction

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid  <= 1'b0;
			in_ch.sample <= '0;
			src_hold     <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				predict_level(in_ch.sample);
			if (!in_ch.valid || in_ch.ready) begin
				if (src_hold > 0) begin
					src_hold    <= src_hold - 1;
					in_ch.valid <= 1'b0;
				end else if (src_bursty && $urandom_range(0, 5) == 0) begin
					src_hold    <= $urandom_range(0, 14);
					in_ch.valid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					in_ch.valid  <= 1'b1;
					in_ch.sample <= sample_q.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		level_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			snk_hold     <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (level_exp.size() == 0) begin
					$error("unexpected result transaction: pct %0d avg %0d fault %0d",
						out_ch.level_percent, out_ch.average, out_ch.span_fault);
					err_cnt++;
				end else begin
					e = level_exp.pop_front();
					if (out_ch.level_percent !== e.pct) begin
						$error("level_percent: expected %0d, got %0d", e.pct,
							out_ch.level_percent);
						err_cnt++;
					end
					if (out_ch.average !== e.avg) begin
						$error("average: expected %0d, got %0d", e.avg, out_ch.average);
						err_cnt++;
					end
					if (out_ch.span_fault !== e.fault) begin
						$error("span_fault: expected %0d, got %0d", e.fault,
							out_ch.span_fault);
						err_cnt++;
					end
				end
			end
			if (snk_hold > 0) begin
				snk_hold     <= snk_hold - 1;
				out_ch.ready <= 1'b0;
			end else if (snk_bursty && $urandom_range(0, 5) == 0) begin
				snk_hold     <= $urandom_range(0, 14);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(psel && penable))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_MAX) begin
			$display("tb_moving_average_level_percent_top: errors");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic wait_drained();
		while (sample_q.size() != 0 || in_ch.valid || level_exp.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(input logic reg_idx, input logic [SAMPLE_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= (reg_idx == REG_SPAN_LOW) ? ADDR_SPAN_LOW : ADDR_SPAN_HIGH;
		pwdata  <= APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (reg_idx == REG_SPAN_LOW)
			span_lo = val;
		else
			span_hi = val;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_span(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi);
		wait_drained();
		apb_write(REG_SPAN_LOW, lo);
		apb_write(REG_SPAN_HIGH, hi);
		@(negedge clk);
	endtask

	// Queue one run of samples: mostly steady levels around the span with noise,
	// some full-range noise and some rail-to-rail swings.
	task automatic queue_run(input int max_len, output int n);
		int kind;
		int lo;
		int hi;
		int margin;
		int level;
		int noise;
		int v;
		lo     = (span_lo < span_hi) ? int'(span_lo) : int'(span_hi);
		hi     = (span_lo < span_hi) ? int'(span_hi) : int'(span_lo);
		margin = (hi - lo) / 8 + 64;
		kind   = $urandom_range(0, 19);
		n      = $urandom_range(3, 30);
		if (n > max_len)
			n = max_len;
		level  = $urandom_range((hi + margin > 65535) ? 65535 : hi + margin,
			(lo - margin < 0) ? 0 : lo - margin);
		noise  = $urandom_range(0, (hi - lo) / 16 + 8);
		for (int i = 0; i < n; i++) begin
			if (kind < 12) begin
				v = level + $urandom_range(0, 2 * noise) - noise;
				v = (v < 0) ? 0 : (v > 65535) ? 65535 : v;
			end else if (kind < 17) begin
				v = $urandom_range(0, 65535);
			end else begin
				v = $urandom_range(0, 1) ? 65535 : 0;
			end
			sample_q.push_back(SAMPLE_W'(v));
		end
	endtask

	initial begin
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		int                  left;
		int                  n;

		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_ch.valid  = 1'b0;
		in_ch.sample = '0;
		out_ch.ready = 1'b0;
		src_bursty   = 1'b1;
		snk_bursty   = 1'b1;
		quiet_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset span: warm-up at full scale, wrap, then both rails
		repeat (10) sample_q.push_back(16'hFFFF);
		sample_q.push_back(16'h0000);
		sample_q.push_back(16'd32640);

		// zero span
		set_span(16'd1000, 16'd1000);
		sample_q.push_back(16'd500);
		sample_q.push_back(16'd1000);
		sample_q.push_back(16'hFFFF);

		// inverted span at the extremes
		set_span(16'hFFFF, 16'h0000);
		sample_q.push_back(16'h0000);
		sample_q.push_back(16'hFFFF);
		sample_q.push_back(16'd30000);

		// full span
		set_span(16'h0000, 16'hFFFF);
		sample_q.push_back(16'hFFFF);
		sample_q.push_back(16'h0000);
		sample_q.push_back(16'h8000);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin lo = 16'h0000; hi = 16'hFFFF; end
				1: begin lo = 16'hFFFF; hi = 16'hFFFF; end
				4: begin lo = SAMPLE_W'($urandom_range(0, 65534)); hi = lo + 1'b1; end
				5: begin lo = 16'h0000; hi = 16'h0000; end
				7: begin lo = 16'd1000; hi = 16'd30000; end
				default: begin
					lo = SAMPLE_W'($urandom_range(0, 65535));
					hi = SAMPLE_W'($urandom_range(0, 65535));
				end
			endcase
			set_span(lo, hi);
			src_bursty = (p != 7) && (p % 3 != 2);
			snk_bursty = (p != 7) && (p % 4 != 3);
			left = PHASE_ITEMS;
			while (left > 0) begin
				queue_run(left, n);
				left -= n;
			end
		end

		wait_drained();
		if (err_cnt == 0)
			$display("tb_moving_average_level_percent_top: clean");
		else
			$display("tb_moving_average_level_percent_top: errors");
		$finish;
	end

endmodule
